/* sv/ird_pkg.sv */
// Shared types and constants for the image row deframer.
// No dependencies; used by every module of the block.
package ird_pkg;

  localparam logic [7:0] START_CHAR = 8'h59;  // 'Y'
  localparam logic [7:0] SEP_CHAR   = 8'h3A;  // ':'

  localparam int ADDR_W = 10;
  localparam int ROW_W  = 8;

  // queue depth is a power of two so the pointers wrap on their own
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_LVL_W = 2;

  typedef enum logic [1:0] {
    FS_START,
    FS_SEP,
    FS_ROWNUM,
    FS_PIXELS
  } front_state_t;

  typedef enum logic {
    BS_FILL,
    BS_FLUSH
  } back_state_t;

  // pixel transaction handed from the front to the back
  typedef struct packed {
    logic [7:0]       pixel;
    logic             last;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pixel;
    logic              last;
  } wr_t;

endpackage

/* sv/image_row_deframer_unit.sv */
// Image row deframer: one received byte per cycle in while in_full is low; a completed
// row leaves as ROW_BYTES frame-store writes through the row-store read register and
// the two-entry result queue, which also pace a flush; meanwhile the front takes the
// next header and 2 pixel bytes.
// Reset (synchronous, active low) clears parser, sequencer and queues; the row
// store is not cleared, since every entry is written before a flush reads it.
module image_row_deframer_unit #(
  parameter int ROW_BYTES = 16,
  parameter int NUM_ROWS  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ird_pkg::ADDR_W-1:0]  out_frame_address,
  output logic [7:0]                  out_pixel_byte,
  output logic                        out_last_of_row
);

  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  ird_pkg::cmd_t cmd_in;
  ird_pkg::cmd_t cmd_out;
  logic [ird_pkg::FIFO_LVL_W-1:0] cmd_level;

  ird_front #(
    .ROW_BYTES (ROW_BYTES),
    .NUM_ROWS  (NUM_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full)
  );

  ird_fifo #(
    .WIDTH ($bits(ird_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty),
    .level (cmd_level)
  );

  ird_back #(
    .ROW_BYTES (ROW_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_empty         (cmd_empty),
    .cmd               (cmd_out),
    .cmd_pop           (cmd_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_frame_address (out_frame_address),
    .out_pixel_byte    (out_pixel_byte),
    .out_last_of_row   (out_last_of_row)
  );

  a_cmd_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_full |-> (cmd_level == ird_pkg::FIFO_LVL_W'(ird_pkg::FIFO_DEPTH)))
    else $error("transaction queue level out of step with full flag");

endmodule

/* sv/ird_fifo.sv */
// Two-entry register queue used between the front and back and on the result side.
// Depends on ird_pkg for the depth and level width.
module ird_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [WIDTH-1:0]              wdata,
  output logic                          full,
  input  logic                          pop,
  output logic [WIDTH-1:0]              rdata,
  output logic                          empty,
  output logic [ird_pkg::FIFO_LVL_W-1:0] level
);

  logic [WIDTH-1:0]               ent_r [ird_pkg::FIFO_DEPTH];
  logic [ird_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [ird_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [ird_pkg::FIFO_LVL_W-1:0] cnt_r;
  logic [ird_pkg::FIFO_LVL_W-1:0] cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (cnt_r == ird_pkg::FIFO_LVL_W'(ird_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rdata   = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* sv/ird_front.sv */
// Front end: parses the row header and turns pixel bytes into queued transactions.
// Depends on ird_pkg for the state type, header characters and cmd_t.
module ird_front #(
  parameter int ROW_BYTES = 16,
  parameter int NUM_ROWS  = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_rx_byte,
  output logic          in_full,
  output logic          cmd_push,
  output ird_pkg::cmd_t cmd,
  input  logic          cmd_full
);

  localparam int COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  ird_pkg::front_state_t       state_r;
  ird_pkg::front_state_t       state_nxt;
  logic [COL_W-1:0]            col_r;
  logic [COL_W-1:0]            col_nxt;
  logic [ird_pkg::ROW_W-1:0]   row_r;
  logic [ird_pkg::ROW_W-1:0]   row_nxt;
  logic                        accept;
  logic                        col_last;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign col_last = (col_r == COL_W'(ROW_BYTES - 1));

  assign cmd.pixel = in_rx_byte;
  assign cmd.last  = col_last;
  assign cmd.row   = row_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cmd_push  = 1'b0;
    if (accept) begin
      case (state_r)
        ird_pkg::FS_START: begin
          if (in_rx_byte == ird_pkg::START_CHAR) begin
            state_nxt = ird_pkg::FS_SEP;
          end
        end
        ird_pkg::FS_SEP: begin
          // a bad separator is dropped, not rechecked as a start byte
          if (in_rx_byte == ird_pkg::SEP_CHAR) begin
            state_nxt = ird_pkg::FS_ROWNUM;
          end else begin
            state_nxt = ird_pkg::FS_START;
          end
        end
        ird_pkg::FS_ROWNUM: begin
          // redirect out-of-range rows to row 0
          if ({1'b0, in_rx_byte} < 9'(NUM_ROWS)) begin
            row_nxt = in_rx_byte;
          end else begin
            row_nxt = '0;
          end
          col_nxt   = '0;
          state_nxt = ird_pkg::FS_PIXELS;
        end
        ird_pkg::FS_PIXELS: begin
          cmd_push = 1'b1;
          if (col_last) begin
            col_nxt   = '0;
            state_nxt = ird_pkg::FS_START;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        default: begin
          state_nxt = ird_pkg::FS_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ird_pkg::FS_START;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  a_rownum_starts_row: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r == ird_pkg::FS_ROWNUM) |=>
      (state_r == ird_pkg::FS_PIXELS && col_r == '0))
    else $error("row header did not start a pixel run at column 0");

endmodule

/* sv/ird_back.sv */
// Back end: row store, flush sequencer and result queue.
// Depends on ird_pkg (cmd_t, wr_t, back_state_t) and ird_fifo.
module ird_back #(
  parameter int ROW_BYTES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_empty,
  input  ird_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ird_pkg::ADDR_W-1:0]  out_frame_address,
  output logic [7:0]                  out_pixel_byte,
  output logic                        out_last_of_row
);

  localparam int COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int PROD_W = ird_pkg::ROW_W + 7;

  logic [7:0] mem [ROW_BYTES];

  ird_pkg::back_state_t              state_r;
  ird_pkg::back_state_t              state_nxt;
  logic [COL_W-1:0]                  wr_idx_r;
  logic [COL_W-1:0]                  wr_idx_nxt;
  logic [COL_W-1:0]                  rd_idx_r;
  logic [COL_W-1:0]                  rd_idx_nxt;
  logic [ird_pkg::ADDR_W-1:0]        addr_r;
  logic [ird_pkg::ADDR_W-1:0]        addr_nxt;
  logic                              pend_r;
  logic [ird_pkg::ADDR_W-1:0]        pend_addr_r;
  logic                              pend_last_r;
  logic [7:0]                        rd_data_r;
  logic                              wr_en;
  logic                              issue;
  logic                              rd_last;
  logic [PROD_W-1:0]                 base;
  logic [ird_pkg::FIFO_LVL_W-1:0]    oq_level;
  logic                              oq_full;
  ird_pkg::wr_t                      oq_wdata;
  ird_pkg::wr_t                      oq_rdata;

  assign base    = PROD_W'(cmd.row) * PROD_W'(ROW_BYTES);
  assign rd_last = (rd_idx_r == COL_W'(ROW_BYTES - 1));

  always_comb begin
    state_nxt  = state_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    addr_nxt   = addr_r;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    issue      = 1'b0;
    case (state_r)
      ird_pkg::BS_FILL: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          wr_en   = 1'b1;
          if (cmd.last) begin
            wr_idx_nxt = '0;
            rd_idx_nxt = '0;
            addr_nxt   = base[ird_pkg::ADDR_W-1:0];
            state_nxt  = ird_pkg::BS_FLUSH;
          end else begin
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
        end
      end
      ird_pkg::BS_FLUSH: begin
        // read only when the result queue has room for the data in flight
        if ((3'(oq_level) + 3'(pend_r)) < 3'(ird_pkg::FIFO_DEPTH)) begin
          issue    = 1'b1;
          addr_nxt = addr_r + 1'b1;
          if (rd_last) begin
            rd_idx_nxt = '0;
            state_nxt  = ird_pkg::BS_FILL;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ird_pkg::BS_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ird_pkg::BS_FILL;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      addr_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      addr_r   <= addr_nxt;
      pend_r   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_r] <= cmd.pixel;
    end
    if (issue) begin
      rd_data_r   <= mem[rd_idx_r];
      pend_addr_r <= addr_r;
      pend_last_r <= rd_last;
    end
  end

  assign oq_wdata.addr  = pend_addr_r;
  assign oq_wdata.pixel = rd_data_r;
  assign oq_wdata.last  = pend_last_r;

  ird_fifo #(
    .WIDTH ($bits(ird_pkg::wr_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pend_r),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty),
    .level (oq_level)
  );

  assign out_frame_address = oq_rdata.addr;
  assign out_pixel_byte    = oq_rdata.pixel;
  assign out_last_of_row   = oq_rdata.last;

  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !oq_full)
    else $error("store read landed on a full result queue");

  a_no_fill_during_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ird_pkg::BS_FLUSH) |-> (!cmd_pop && !wr_en))
    else $error("row store written while a flush is in progress");

  a_last_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.last) |=>
      (state_r == ird_pkg::BS_FLUSH && rd_idx_r == '0 && wr_idx_r == '0))
    else $error("end of row did not start a flush at column 0");

endmodule
